// ===== rtl/svm_pkg.sv =====
// Shared types and constants for the stereo voice mixer.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package svm_pkg;

    // fixed slot count of the port list and sample format
    localparam int SLOT_COUNT = 4;
    localparam int SLOT_IDX_W = 2;
    localparam int SAMPLE_W   = 16;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // request function codes
    typedef enum logic
    {
        FUNC_PLAY = 1'b0,
        FUNC_MIX  = 1'b1
    } svm_func_t;

    // what one lane hands to the merge stage
    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } svm_contrib_t;

    // one request between the lane stage and the merge stage
    typedef struct packed
    {
        svm_contrib_t [SLOT_COUNT-1:0] lanes;
        logic [SLOT_IDX_W-1:0]         granted;
        logic                          dropped;
        logic [SLOT_COUNT-1:0]         flags;
    } svm_stage_t;

endpackage

// ===== rtl/stereo_voice_mixer_with_slots.sv =====
// Top level of the stereo voice mixer: slot state, claim logic, lanes, pipeline control.
// Depends on svm_pkg, svm_lane and svm_merge.
`timescale 1ns / 1ps

// Takes a play or mix request per clock cycle while req_stall is low and returns
// one result per request through the lane and result registers. The rate is set
// by the slot flag register, which is read and rewritten in the same cycle a
// request is taken; one lane per slot gates its samples and a merge stage clips
// the slot-ordered sums before the result register. A lane register and the result
// register keep requests flowing while a result waits on the output. NUM_SLOTS
// (1 to 4) sets how many slots are in use; the unused slots never play and read zero.
module stereo_voice_mixer_with_slots
#(
    parameter int NUM_SLOTS = 4
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [0:0]                          func,
    input  logic [3:0]                          finished_mask,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] left0,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] right0,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] left1,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] right1,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] left2,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] right2,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] left3,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] right3,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic signed [svm_pkg::SAMPLE_W-1:0] mix_left,
    output logic signed [svm_pkg::SAMPLE_W-1:0] mix_right,
    output logic [svm_pkg::SLOT_IDX_W-1:0]      granted_slot,
    output logic                                play_dropped,
    output logic [3:0]                          active_flags
);

    localparam int LANES = svm_pkg::SLOT_COUNT;

    svm_pkg::svm_func_t                  func_code;
    logic signed [svm_pkg::SAMPLE_W-1:0] left_in  [LANES];
    logic signed [svm_pkg::SAMPLE_W-1:0] right_in [LANES];

    logic [LANES-1:0]                    active_reg;
    logic [LANES-1:0]                    active_next;
    logic [LANES-1:0]                    lane_next;
    logic [LANES-1:0]                    claim;
    logic [svm_pkg::SLOT_IDX_W-1:0]      grant_idx;
    logic                                grant_found;
    svm_pkg::svm_contrib_t [LANES-1:0]   contrib;

    svm_pkg::svm_stage_t                 stage_next;
    svm_pkg::svm_stage_t                 stage_reg;
    logic                                stage_valid_reg;
    logic                                rsp_valid_reg;
    logic                                adv_out;
    logic                                adv_stage;
    logic                                accept;

    assign func_code = svm_pkg::svm_func_t'(func);

    assign left_in[0]  = left0;
    assign left_in[1]  = left1;
    assign left_in[2]  = left2;
    assign left_in[3]  = left3;
    assign right_in[0] = right0;
    assign right_in[1] = right1;
    assign right_in[2] = right2;
    assign right_in[3] = right3;

    // pipeline control: each register moves when the one after it frees up
    assign adv_out   = !rsp_valid_reg || !rsp_stall;
    assign adv_stage = !stage_valid_reg || adv_out;
    assign req_stall = !adv_stage;
    assign accept    = req_valid && adv_stage;

    // lowest free slot among those in use
    always_comb
    begin
        claim       = '0;
        grant_idx   = '0;
        grant_found = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            if (i < NUM_SLOTS && !grant_found && !active_reg[i])
            begin
                claim[i]    = 1'b1;
                grant_idx   = svm_pkg::SLOT_IDX_W'(i);
                grant_found = 1'b1;
            end
        end
    end

    // one lane per slot in use, unused slots stay inactive
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        if (g < NUM_SLOTS)
        begin : g_used
            svm_lane u_lane
            (
                .func        (func_code),
                .active      (active_reg[g]),
                .finished    (finished_mask[g]),
                .claim       (claim[g]),
                .left        (left_in[g]),
                .right       (right_in[g]),
                .active_next (lane_next[g]),
                .contrib     (contrib[g])
            );
        end
        else
        begin : g_unused
            assign lane_next[g] = 1'b0;
            assign contrib[g]   = '0;
        end
    end

    assign active_next = lane_next;

    // fields carried to the merge stage
    always_comb
    begin
        stage_next.lanes = contrib;
        stage_next.flags = active_next;
        if (func_code == svm_pkg::FUNC_PLAY)
        begin
            stage_next.granted = grant_found ? grant_idx : '0;
            stage_next.dropped = !grant_found;
        end
        else
        begin
            stage_next.granted = '0;
            stage_next.dropped = 1'b0;
        end
    end

    // slot flags and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= '0;
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                active_reg <= active_next;
            end
            if (adv_stage)
            begin
                stage_valid_reg <= req_valid;
            end
            if (adv_out)
            begin
                rsp_valid_reg <= stage_valid_reg;
            end
        end
    end

    // lane stage register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

    svm_merge u_merge
    (
        .clk          (clk),
        .load         (adv_out && stage_valid_reg),
        .stage        (stage_reg),
        .mix_left     (mix_left),
        .mix_right    (mix_right),
        .granted_slot (granted_slot),
        .play_dropped (play_dropped),
        .active_flags (active_flags)
    );

    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== rtl/svm_lane.sv =====
// One voice slot lane: next active flag and gated stereo contribution.
// Depends on svm_pkg.
`timescale 1ns / 1ps

module svm_lane
(
    input  svm_pkg::svm_func_t                func,
    input  logic                              active,
    input  logic                              finished,
    input  logic                              claim,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] left,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] right,
    output logic                              active_next,
    output svm_pkg::svm_contrib_t             contrib
);

    logic mixing;

    // slot adds in only when active, not finished, on a mix request
    assign mixing = (func == svm_pkg::FUNC_MIX) && active && !finished;

    // play sets the claimed flag, mix clears finished slots
    always_comb
    begin
        if (func == svm_pkg::FUNC_PLAY)
        begin
            active_next = active | claim;
        end
        else
        begin
            active_next = active & ~finished;
        end
    end

    // zero contributes nothing to a saturating sum already in range
    assign contrib.left  = mixing ? left  : '0;
    assign contrib.right = mixing ? right : '0;

endmodule

// ===== rtl/svm_merge.sv =====
// Merge stage: saturating sum of lane contributions in slot order, output register.
// Depends on svm_pkg.
`timescale 1ns / 1ps

module svm_merge
(
    input  logic                                clk,
    input  logic                                load,
    input  svm_pkg::svm_stage_t                 stage,
    output logic signed [svm_pkg::SAMPLE_W-1:0] mix_left,
    output logic signed [svm_pkg::SAMPLE_W-1:0] mix_right,
    output logic [svm_pkg::SLOT_IDX_W-1:0]      granted_slot,
    output logic                                play_dropped,
    output logic [svm_pkg::SLOT_COUNT-1:0]      active_flags
);

    logic signed [svm_pkg::SAMPLE_W-1:0] sum_left;
    logic signed [svm_pkg::SAMPLE_W-1:0] sum_right;

    logic signed [svm_pkg::SAMPLE_W-1:0] mix_left_reg;
    logic signed [svm_pkg::SAMPLE_W-1:0] mix_right_reg;
    logic [svm_pkg::SLOT_IDX_W-1:0]      granted_reg;
    logic                                dropped_reg;
    logic [svm_pkg::SLOT_COUNT-1:0]      flags_reg;

    // add with clipping to the 16-bit range
    function automatic logic signed [svm_pkg::SAMPLE_W-1:0] sat_add
    (
        input logic signed [svm_pkg::SAMPLE_W-1:0] acc,
        input logic signed [svm_pkg::SAMPLE_W-1:0] s
    );
        logic signed [svm_pkg::SAMPLE_W:0] wide;
        logic signed [svm_pkg::SAMPLE_W-1:0] res;
        wide = {acc[svm_pkg::SAMPLE_W-1], acc} + {s[svm_pkg::SAMPLE_W-1], s};
        if (wide[svm_pkg::SAMPLE_W] != wide[svm_pkg::SAMPLE_W-1])
        begin
            res = wide[svm_pkg::SAMPLE_W] ? svm_pkg::SAMPLE_MIN : svm_pkg::SAMPLE_MAX;
        end
        else
        begin
            res = wide[svm_pkg::SAMPLE_W-1:0];
        end
        return res;
    endfunction

    // slot-ordered chain, later slots add to the clipped value
    always_comb
    begin
        sum_left  = '0;
        sum_right = '0;
        for (int i = 0; i < svm_pkg::SLOT_COUNT; i++)
        begin
            sum_left  = sat_add(sum_left,  stage.lanes[i].left);
            sum_right = sat_add(sum_right, stage.lanes[i].right);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mix_left_reg  <= sum_left;
            mix_right_reg <= sum_right;
            granted_reg   <= stage.granted;
            dropped_reg   <= stage.dropped;
            flags_reg     <= stage.flags;
        end
    end

    assign mix_left     = mix_left_reg;
    assign mix_right    = mix_right_reg;
    assign granted_slot = granted_reg;
    assign play_dropped = dropped_reg;
    assign active_flags = flags_reg;

endmodule

// ===== tb/sv/svm_mix_checker.sv =====
// Checker for the stereo voice mixer: watches both channels, predicts each result
// from its own copy of the slot flags and compares in order. Depends on svm_pkg.
`timescale 1ns / 1ps

module svm_mix_checker
#(
    parameter int NUM_SLOTS = 4
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_stall,
    input  logic [0:0]                          func,
    input  logic [3:0]                          finished_mask,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] left0,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] right0,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] left1,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] right1,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] left2,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] right2,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] left3,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] right3,
    input  logic                                rsp_valid,
    input  logic                                rsp_stall,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] mix_left,
    input  logic signed [svm_pkg::SAMPLE_W-1:0] mix_right,
    input  logic [svm_pkg::SLOT_IDX_W-1:0]      granted_slot,
    input  logic                                play_dropped,
    input  logic [3:0]                          active_flags,
    output int                                  errors,
    output int                                  pending
);

    // one result as the block should return it
    typedef struct packed
    {
        logic signed [svm_pkg::SAMPLE_W-1:0] left;
        logic signed [svm_pkg::SAMPLE_W-1:0] right;
        logic [svm_pkg::SLOT_IDX_W-1:0]      slot;
        logic                                dropped;
        logic [3:0]                          flags;
    } mix_result_t;

    logic [3:0]  slot_busy;
    mix_result_t expected_mixes[$];
    int          fail_total;

    // one saturating step of the slot-ordered accumulation
    function automatic logic signed [svm_pkg::SAMPLE_W-1:0] clip_add(
        input logic signed [svm_pkg::SAMPLE_W-1:0] acc,
        input logic signed [svm_pkg::SAMPLE_W-1:0] smp
    );
        int sum;
        sum = int'(acc) + int'(smp);
        if (sum > int'(svm_pkg::SAMPLE_MAX))
        begin
            return svm_pkg::SAMPLE_MAX;
        end
        if (sum < int'(svm_pkg::SAMPLE_MIN))
        begin
            return svm_pkg::SAMPLE_MIN;
        end
        return sum[svm_pkg::SAMPLE_W-1:0];
    endfunction

    // apply one request to the slot flags and return the result it causes
    function automatic mix_result_t mix_outcome(
        input svm_pkg::svm_func_t                  fn,
        input logic [3:0]                          done,
        input logic [3:0][svm_pkg::SAMPLE_W-1:0]   lv,
        input logic [3:0][svm_pkg::SAMPLE_W-1:0]   rv
    );
        mix_result_t res;
        logic        found;
        res   = '0;
        found = 1'b0;
        if (fn == svm_pkg::FUNC_PLAY)
        begin
            // lowest free slot wins
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (!found && !slot_busy[i])
                begin
                    slot_busy[i] = 1'b1;
                    res.slot     = i[svm_pkg::SLOT_IDX_W-1:0];
                    found        = 1'b1;
                end
            end
            res.dropped = !found;
        end
        else
        begin
            // finished slots are freed, the rest add in slot order
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (slot_busy[i])
                begin
                    if (done[i])
                    begin
                        slot_busy[i] = 1'b0;
                    end
                    else
                    begin
                        res.left  = clip_add(res.left, $signed(lv[i]));
                        res.right = clip_add(res.right, $signed(rv[i]));
                    end
                end
            end
        end
        res.flags = slot_busy;
        return res;
    endfunction

    // sample both channels at the edge, response side first
    always @(posedge clk)
    begin
        mix_result_t want;
        mix_result_t got;
        if (!rst_n)
        begin
            slot_busy = '0;
            expected_mixes.delete();
            fail_total = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got = '{mix_left, mix_right, granted_slot, play_dropped, active_flags};
                if (expected_mixes.size() == 0)
                begin
                    if (fail_total < 10)
                    begin
                        $display("%0t: result with no request waiting: L=%0d R=%0d slot=%0d",
                                 $realtime, got.left, got.right, got.slot);
                    end
                    fail_total++;
                end
                else
                begin
                    want = expected_mixes.pop_front();
                    if (got.left !== want.left || got.right !== want.right ||
                        got.slot !== want.slot || got.dropped !== want.dropped ||
                        got.flags !== want.flags)
                    begin
                        if (fail_total < 10)
                        begin
                            $display("%0t: mismatch exp L=%0d R=%0d slot=%0d drop=%0b flags=%b",
                                     $realtime, want.left, want.right, want.slot,
                                     want.dropped, want.flags);
                            $display("%0t:          got L=%0d R=%0d slot=%0d drop=%0b flags=%b",
                                     $realtime, got.left, got.right, got.slot,
                                     got.dropped, got.flags);
                        end
                        fail_total++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                expected_mixes.push_back(
                    mix_outcome(svm_pkg::svm_func_t'(func), finished_mask,
                                {left3, left2, left1, left0},
                                {right3, right2, right1, right0}));
            end
        end
        pending <= expected_mixes.size();
        errors  <= fail_total;
    end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the mixer testbench: clock, reset, request stimulus, response stalls, verdict.
// Depends on svm_pkg, stereo_voice_mixer_with_slots and svm_mix_checker.
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS       = 4;
    localparam int RAND_ITEMS  = 800;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 10;

    logic                                clk;
    logic                                rst_n;
    logic                                req_valid;
    logic                                req_stall;
    logic [0:0]                          func;
    logic [3:0]                          finished_mask;
    logic signed [svm_pkg::SAMPLE_W-1:0] left0;
    logic signed [svm_pkg::SAMPLE_W-1:0] right0;
    logic signed [svm_pkg::SAMPLE_W-1:0] left1;
    logic signed [svm_pkg::SAMPLE_W-1:0] right1;
    logic signed [svm_pkg::SAMPLE_W-1:0] left2;
    logic signed [svm_pkg::SAMPLE_W-1:0] right2;
    logic signed [svm_pkg::SAMPLE_W-1:0] left3;
    logic signed [svm_pkg::SAMPLE_W-1:0] right3;
    logic                                rsp_valid;
    logic                                rsp_stall;
    logic signed [svm_pkg::SAMPLE_W-1:0] mix_left;
    logic signed [svm_pkg::SAMPLE_W-1:0] mix_right;
    logic [svm_pkg::SLOT_IDX_W-1:0]      granted_slot;
    logic                                play_dropped;
    logic [3:0]                          active_flags;

    int errors;
    int pending;
    int req_idle_pct;
    int rsp_stall_pct;
    int quiet_cycles;

    stereo_voice_mixer_with_slots #(.NUM_SLOTS(SLOTS)) dut
    (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .func(func), .finished_mask(finished_mask),
        .left0(left0), .right0(right0), .left1(left1), .right1(right1),
        .left2(left2), .right2(right2), .left3(left3), .right3(right3),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .mix_left(mix_left), .mix_right(mix_right), .granted_slot(granted_slot),
        .play_dropped(play_dropped), .active_flags(active_flags)
    );

    svm_mix_checker #(.NUM_SLOTS(SLOTS)) u_checker
    (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .func(func), .finished_mask(finished_mask),
        .left0(left0), .right0(right0), .left1(left1), .right1(right1),
        .left2(left2), .right2(right2), .left3(left3), .right3(right3),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .mix_left(mix_left), .mix_right(mix_right), .granted_slot(granted_slot),
        .play_dropped(play_dropped), .active_flags(active_flags),
        .errors(errors), .pending(pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // response side stalls at random
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL stereo_voice_mixer_with_slots");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one request, held until taken, after a random idle gap
    task automatic send_req(
        input svm_pkg::svm_func_t                fn,
        input logic [3:0]                        done,
        input logic [3:0][svm_pkg::SAMPLE_W-1:0] lv,
        input logic [3:0][svm_pkg::SAMPLE_W-1:0] rv
    );
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid     <= 1'b1;
        func          <= fn;
        finished_mask <= done;
        left0  <= lv[0];
        right0 <= rv[0];
        left1  <= lv[1];
        right1 <= rv[1];
        left2  <= lv[2];
        right2 <= rv[2];
        left3  <= lv[3];
        right3 <= rv[3];
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
    endtask

    // samples lean toward the rails and zero
    function automatic logic [svm_pkg::SAMPLE_W-1:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(15))
            0: return svm_pkg::SAMPLE_MAX;
            1: return svm_pkg::SAMPLE_MIN;
            2: return '0;
            default: return r[svm_pkg::SAMPLE_W-1:0];
        endcase
    endfunction

    initial
    begin
        logic [3:0][svm_pkg::SAMPLE_W-1:0] lv;
        logic [3:0][svm_pkg::SAMPLE_W-1:0] rv;
        logic [3:0]                        done;
        logic [31:0]                       r;
        svm_pkg::svm_func_t                fn;

        rst_n         = 1'b0;
        req_valid     = 1'b0;
        rsp_stall     = 1'b0;
        func          = svm_pkg::FUNC_PLAY;
        finished_mask = '0;
        {left0, right0, left1, right1, left2, right2, left3, right3} = '0;
        quiet_cycles  = 0;
        req_idle_pct  = 30;
        rsp_stall_pct = 69;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // mix with no slot active, then with every finished mark on idle slots
        send_req(svm_pkg::FUNC_MIX, 4'h0, {4{svm_pkg::SAMPLE_MAX}}, {4{svm_pkg::SAMPLE_MIN}});
        send_req(svm_pkg::FUNC_MIX, 4'hF, {4{16'h1234}}, {4{16'h8765}});
        // fill all slots, play inputs carry junk that must be ignored
        send_req(svm_pkg::FUNC_PLAY, 4'hF, {4{svm_pkg::SAMPLE_MAX}}, {4{svm_pkg::SAMPLE_MAX}});
        send_req(svm_pkg::FUNC_PLAY, 4'hA, {4{svm_pkg::SAMPLE_MIN}}, {4{16'h5555}});
        send_req(svm_pkg::FUNC_PLAY, 4'h5, {4{16'hAAAA}}, {4{svm_pkg::SAMPLE_MIN}});
        send_req(svm_pkg::FUNC_PLAY, 4'h0, '0, '0);
        // no free slot left
        send_req(svm_pkg::FUNC_PLAY, 4'h0, {4{16'hFFFF}}, {4{16'h0001}});
        // saturate to both rails
        send_req(svm_pkg::FUNC_MIX, 4'h0, {4{svm_pkg::SAMPLE_MAX}}, {4{svm_pkg::SAMPLE_MIN}});
        // clipped value feeds later slots
        lv = {16'hFFFF, svm_pkg::SAMPLE_MIN, svm_pkg::SAMPLE_MAX, svm_pkg::SAMPLE_MAX};
        rv = {16'h0001, svm_pkg::SAMPLE_MAX, svm_pkg::SAMPLE_MIN, svm_pkg::SAMPLE_MIN};
        send_req(svm_pkg::FUNC_MIX, 4'h0, lv, rv);
        send_req(svm_pkg::FUNC_MIX, 4'h0, {16'd4, 16'd3, 16'd2, 16'd1},
                 {16'hFFFC, 16'hFFFD, 16'hFFFE, 16'hFFFF});
        // free slot 1, then mark it again while inactive
        send_req(svm_pkg::FUNC_MIX, 4'h2, {4{16'h4000}}, {4{16'hC000}});
        send_req(svm_pkg::FUNC_MIX, 4'h2, {4{16'h4000}}, {4{16'hC000}});
        send_req(svm_pkg::FUNC_PLAY, 4'h0, '0, '0);
        send_req(svm_pkg::FUNC_MIX, 4'h9, {16'd100, 16'd200, 16'd300, 16'd400},
                 {16'd7, 16'd6, 16'd5, 16'd4});
        send_req(svm_pkg::FUNC_PLAY, 4'h0, '0, '0);
        send_req(svm_pkg::FUNC_PLAY, 4'h0, '0, '0);
        send_req(svm_pkg::FUNC_PLAY, 4'h0, '0, '0);
        // release everything at once
        send_req(svm_pkg::FUNC_MIX, 4'hF, {4{svm_pkg::SAMPLE_MAX}}, {4{svm_pkg::SAMPLE_MAX}});
        send_req(svm_pkg::FUNC_MIX, 4'h0, {4{svm_pkg::SAMPLE_MAX}}, {4{svm_pkg::SAMPLE_MAX}});
        send_req(svm_pkg::FUNC_PLAY, 4'h0, '0, '0);

        // random traffic in three idle/stall phases
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == RAND_ITEMS / 3)
            begin
                req_idle_pct  = 69;
                rsp_stall_pct = 30;
            end
            else if (n == 2 * RAND_ITEMS / 3)
            begin
                req_idle_pct  = 0;
                rsp_stall_pct = 0;
            end
            fn = ($urandom_range(99) < 35) ? svm_pkg::FUNC_PLAY : svm_pkg::FUNC_MIX;
            done = '0;
            if ($urandom_range(9) == 0)
            begin
                r    = $urandom;
                done = r[3:0];
            end
            else
            begin
                for (int b = 0; b < 4; b++)
                begin
                    done[b] = ($urandom_range(99) < 12);
                end
            end
            for (int s = 0; s < 4; s++)
            begin
                lv[s] = pick_sample();
                rv[s] = pick_sample();
            end
            send_req(fn, done, lv, rv);
        end
        req_valid <= 1'b0;

        // drain outstanding results, then let the pipeline settle
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
        begin
            $display("PASS stereo_voice_mixer_with_slots");
        end
        else
        begin
            $display("FAIL stereo_voice_mixer_with_slots");
        end
        $finish;
    end

endmodule
